// ----- src/owl_pkg.sv -----
// Shared types and constants for the ordered wait list with keyed removal.
// No dependencies; used by owl_ctrl, owl_dp and the top level.
package owl_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int MODE_W  = 3;
    localparam int ID_W    = 8;
    localparam int TIME_W  = 16;
    localparam int WAIT_W  = 16;
    localparam int KEY_W   = 17;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 5;
    localparam int ENTRY_W = ID_W + TIME_W + WAIT_W;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POP     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RM_ARR  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RM_WAIT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TICK    = 3'd4;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOMATCH = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RD,
        ST_CHK,
        ST_MV_RD,
        ST_MV_WR,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic              load;      // latch item, clear result, idx to 0
        logic              push_wr;   // write item at tail, count up
        logic              tick_wr;   // write back decremented wait at idx
        logic              move_wr;   // write read data at idx
        logic              rd_next;   // read at idx+1 instead of idx
        logic              idx_inc;
        logic              total_dec;
        logic              set_stat;
        logic [STAT_W-1:0] stat_code;
        logic              take;      // capture read entry as result
    } dp_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              full;
        logic              empty;
        logic              match;     // read entry matches the key
        logic              at_last;   // idx + 1 == total
        logic              mv_last;   // idx + 2 == total
    } dp_stat_t;

endpackage

// ----- src/owl_dp.sv -----
// Datapath: entry memory, scan index, entry count, item and result registers.
// Depends on owl_pkg; driven by owl_ctrl through dp_cmd_t.
module owl_dp #(
    parameter int DEPTH = owl_pkg::DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  owl_pkg::dp_cmd_t                    cmd,
    output owl_pkg::dp_stat_t                   stat,
    input  logic [owl_pkg::MODE_W-1:0]          mode,
    input  logic [owl_pkg::ID_W-1:0]            thread_id,
    input  logic [owl_pkg::TIME_W-1:0]          arrival,
    input  logic signed [owl_pkg::WAIT_W-1:0]   wait_count,
    input  logic signed [owl_pkg::KEY_W-1:0]    match_key,
    output logic [owl_pkg::STAT_W-1:0]          status,
    output logic [owl_pkg::ID_W-1:0]            out_thread_id,
    output logic [owl_pkg::TIME_W-1:0]          out_arrival,
    output logic signed [owl_pkg::WAIT_W-1:0]   out_wait,
    output logic [owl_pkg::OCC_W-1:0]           occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int TLO = owl_pkg::ID_W;
    localparam int WLO = owl_pkg::ID_W + owl_pkg::TIME_W;

    logic [owl_pkg::ENTRY_W-1:0] mem [DEPTH];
    logic [owl_pkg::ENTRY_W-1:0] rd_data_reg;

    logic [AW-1:0] idx_reg;
    logic [CW-1:0] total_reg;

    logic [owl_pkg::MODE_W-1:0]  mode_reg;
    logic [owl_pkg::ID_W-1:0]    id_reg;
    logic [owl_pkg::TIME_W-1:0]  arr_reg;
    logic [owl_pkg::WAIT_W-1:0]  wait_reg;
    logic [owl_pkg::KEY_W-1:0]   key_reg;

    logic [owl_pkg::STAT_W-1:0]  stat_reg;
    logic [owl_pkg::ENTRY_W-1:0] res_reg;

    logic [CW-1:0]               idx_ext;
    logic [CW-1:0]               idx_p1;
    logic [CW-1:0]               idx_p2;
    logic [AW-1:0]               rd_addr;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [owl_pkg::ENTRY_W-1:0] wr_data;
    logic [owl_pkg::WAIT_W-1:0]  rd_wait;
    logic [owl_pkg::WAIT_W-1:0]  dec_wait;
    logic [owl_pkg::TIME_W-1:0]  rd_arr;
    logic [31:0]                 total_wide;

    assign idx_ext = CW'(idx_reg);
    assign idx_p1  = idx_ext + CW'(1);
    assign idx_p2  = idx_ext + CW'(2);
    assign rd_addr = cmd.rd_next ? idx_p1[AW-1:0] : idx_reg;

    assign rd_wait = rd_data_reg[WLO +: owl_pkg::WAIT_W];
    assign rd_arr  = rd_data_reg[TLO +: owl_pkg::TIME_W];
    // saturate at the most negative wait count
    assign dec_wait = (rd_wait == {1'b1, {(owl_pkg::WAIT_W-1){1'b0}}}) ?
                      rd_wait : rd_wait - owl_pkg::WAIT_W'(1);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = rd_data_reg;
        if (cmd.push_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = total_reg[AW-1:0];
            wr_data = {wait_reg, arr_reg, id_reg};
        end
        else if (cmd.tick_wr)
        begin
            wr_en   = 1'b1;
            wr_data = {dec_wait, rd_data_reg[WLO-1:0]};
        end
        else if (cmd.move_wr)
        begin
            wr_en   = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        stat.mode    = mode_reg;
        stat.full    = (total_reg == CW'(DEPTH));
        stat.empty   = (total_reg == '0);
        stat.at_last = (idx_p1 == total_reg);
        stat.mv_last = (idx_p2 == total_reg);
        case (mode_reg)
            owl_pkg::MODE_POP:     stat.match = 1'b1;
            owl_pkg::MODE_RM_ARR:  stat.match = (key_reg == {1'b0, rd_arr});
            owl_pkg::MODE_RM_WAIT: stat.match = (key_reg == {rd_wait[owl_pkg::WAIT_W-1],
                                                             rd_wait});
            default:               stat.match = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            total_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_p1[AW-1:0];
            end
            if (cmd.push_wr)
            begin
                total_reg <= total_reg + CW'(1);
            end
            else if (cmd.total_dec)
            begin
                total_reg <= total_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            id_reg   <= thread_id;
            arr_reg  <= arrival;
            wait_reg <= wait_count;
            key_reg  <= match_key;
            stat_reg <= owl_pkg::STAT_DONE;
            res_reg  <= '0;
        end
        else
        begin
            if (cmd.set_stat)
            begin
                stat_reg <= cmd.stat_code;
            end
            if (cmd.take)
            begin
                res_reg <= rd_data_reg;
            end
        end
    end

    assign total_wide    = 32'(total_reg);
    assign status        = stat_reg;
    assign out_thread_id = res_reg[0 +: owl_pkg::ID_W];
    assign out_arrival   = res_reg[TLO +: owl_pkg::TIME_W];
    assign out_wait      = res_reg[WLO +: owl_pkg::WAIT_W];
    assign occupancy     = total_wide[owl_pkg::OCC_W-1:0];

endmodule

// ----- src/owl_ctrl.sv -----
// Controller state machine: sequences push, scan, compaction and tick passes.
// Depends on owl_pkg; drives owl_dp through dp_cmd_t, reads dp_stat_t.
module owl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  owl_pkg::dp_stat_t stat,
    output owl_pkg::dp_cmd_t  cmd
);

    owl_pkg::ctrl_state_t state_reg;
    owl_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= owl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            owl_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = owl_pkg::ST_EXEC;
                end
            end
            owl_pkg::ST_EXEC:
            begin
                state_next = owl_pkg::ST_OUT;
                case (stat.mode)
                    owl_pkg::MODE_PUSH:
                    begin
                        if (stat.full)
                        begin
                            cmd.set_stat  = 1'b1;
                            cmd.stat_code = owl_pkg::STAT_FULL;
                        end
                        else
                        begin
                            cmd.push_wr = 1'b1;
                        end
                    end
                    owl_pkg::MODE_POP, owl_pkg::MODE_RM_ARR, owl_pkg::MODE_RM_WAIT:
                    begin
                        if (stat.empty)
                        begin
                            cmd.set_stat  = 1'b1;
                            cmd.stat_code = owl_pkg::STAT_NOMATCH;
                        end
                        else
                        begin
                            state_next = owl_pkg::ST_RD;
                        end
                    end
                    owl_pkg::MODE_TICK:
                    begin
                        if (!stat.empty)
                        begin
                            state_next = owl_pkg::ST_RD;
                        end
                    end
                    default:
                    begin
                        state_next = owl_pkg::ST_OUT;
                    end
                endcase
            end
            owl_pkg::ST_RD:
            begin
                state_next = owl_pkg::ST_CHK;
            end
            owl_pkg::ST_CHK:
            begin
                if (stat.mode == owl_pkg::MODE_TICK)
                begin
                    cmd.tick_wr = 1'b1;
                    cmd.idx_inc = 1'b1;
                    state_next  = stat.at_last ? owl_pkg::ST_OUT : owl_pkg::ST_RD;
                end
                else if (stat.match)
                begin
                    cmd.take = 1'b1;
                    if (stat.at_last)
                    begin
                        cmd.total_dec = 1'b1;
                        state_next    = owl_pkg::ST_OUT;
                    end
                    else
                    begin
                        state_next = owl_pkg::ST_MV_RD;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    if (stat.at_last)
                    begin
                        cmd.set_stat  = 1'b1;
                        cmd.stat_code = owl_pkg::STAT_NOMATCH;
                        state_next    = owl_pkg::ST_OUT;
                    end
                    else
                    begin
                        state_next = owl_pkg::ST_RD;
                    end
                end
            end
            owl_pkg::ST_MV_RD:
            begin
                cmd.rd_next = 1'b1;
                state_next  = owl_pkg::ST_MV_WR;
            end
            owl_pkg::ST_MV_WR:
            begin
                cmd.move_wr = 1'b1;
                cmd.idx_inc = 1'b1;
                if (stat.mv_last)
                begin
                    cmd.total_dec = 1'b1;
                    state_next    = owl_pkg::ST_OUT;
                end
                else
                begin
                    state_next = owl_pkg::ST_MV_RD;
                end
            end
            owl_pkg::ST_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = owl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = owl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/ordered_wait_list_keyed_removal.sv -----
// Top level of the ordered wait list with keyed removal.
// Depends on owl_pkg, owl_ctrl and owl_dp.
//
// Slave channel (s_*): one item per operation. s_tuser carries the mode (push,
//   pop head, remove by arrival, remove by wait, tick); s_tdata carries the
//   pushed entry and the match key.
// Master channel (m_*): exactly one result item per accepted item, in order.
//   m_tuser carries the status (done, empty/no match, full); m_tdata carries
//   the removed entry (zero when nothing was removed) and the occupancy.
// Timing: one item in flight. m_tvalid rises right after the execute state for
//   push, unused modes and any operation on an empty list, and after a pass
//   over all N entries for pop, remove and tick on a list of N entries: each
//   entry visited costs a registered memory read plus a check, write-back or
//   move step. s_tready returns the cycle after the result is taken.
// Reset: rst_n clears the controller and empties the list; entry memory is
//   not cleared, entries are only read below the fill count.
// Stall: while m_tready is low the result item holds and s_tready stays low.
module ordered_wait_list_keyed_removal #(
    parameter int DEPTH = owl_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] thread_id, [23:8] arrival, [39:24] wait_count,
    // [56:40] match_key, [63:57] zero
    input  logic [63:0] s_tdata,
    // [2:0] mode
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] out_thread_id, [23:8] out_arrival, [39:24] out_wait,
    // [44:40] occupancy, [47:45] zero
    output logic [47:0] m_tdata,
    // [1:0] status
    output logic [1:0]  m_tuser
);

    owl_pkg::dp_cmd_t  cmd;
    owl_pkg::dp_stat_t stat;

    logic [owl_pkg::STAT_W-1:0]        status;
    logic [owl_pkg::ID_W-1:0]          out_thread_id;
    logic [owl_pkg::TIME_W-1:0]        out_arrival;
    logic signed [owl_pkg::WAIT_W-1:0] out_wait;
    logic [owl_pkg::OCC_W-1:0]         occupancy;

    owl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    owl_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .mode          (s_tuser),
        .thread_id     (s_tdata[7:0]),
        .arrival       (s_tdata[23:8]),
        .wait_count    (s_tdata[39:24]),
        .match_key     (s_tdata[56:40]),
        .status        (status),
        .out_thread_id (out_thread_id),
        .out_arrival   (out_arrival),
        .out_wait      (out_wait),
        .occupancy     (occupancy)
    );

    assign m_tdata = {3'b000, occupancy, out_wait, out_arrival, out_thread_id};
    assign m_tuser = status;

    // input and output never both open: one item in flight
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");

    // an accepted item is not followed by another in the next cycle
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted while busy");

    // a failed operation reports no entry
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != owl_pkg::STAT_DONE) |-> (m_tdata[39:0] == 40'd0))
        else $error("failed operation returned entry data");

    // a full report means the list holds DEPTH entries
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == owl_pkg::STAT_FULL) |->
        (occupancy == owl_pkg::OCC_W'(DEPTH)))
        else $error("full status with wrong occupancy");

endmodule

// ----- tb/ordered_wait_list_keyed_removal_tb.sv -----
// Self-checking testbench for ordered_wait_list_keyed_removal.
// Drives mode/entry items on the s_* stream, checks m_* results against a local list model.
// Depends on owl_pkg and the RTL under src/.
module ordered_wait_list_keyed_removal_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH = owl_pkg::DEPTH_DEF;
    localparam int MODE_LAST  = (1 << owl_pkg::MODE_W) - 1;   // top of the unused mode range
    localparam int RAND_OPS   = 420;
    // worst item: full scan plus compaction, and the return to idle
    localparam int DRAIN_CYC  = 2 * LIST_DEPTH + 4;
    localparam int HOLD_CYC   = 300;                 // long receiver hold-off
    localparam int HOLD_AT    = 80;                  // result count that starts it
    localparam int CALM_LO    = 150;                 // stretch with no idling, by item count
    localparam int CALM_HI    = 260;
    localparam int IDLE_PCT   = 26;

    localparam logic signed [owl_pkg::WAIT_W-1:0] TICKS_FLOOR =
        {1'b1, {(owl_pkg::WAIT_W-1){1'b0}}};

    // one operation on the list
    typedef struct {
        logic [owl_pkg::MODE_W-1:0]        mode;
        logic [owl_pkg::ID_W-1:0]          id;
        logic [owl_pkg::TIME_W-1:0]        arrival;
        logic signed [owl_pkg::WAIT_W-1:0] ticks;
        logic signed [owl_pkg::KEY_W-1:0]  key;
    } wl_op_t;

    // what one operation reports back
    typedef struct {
        logic [owl_pkg::STAT_W-1:0]        status;
        logic [owl_pkg::ID_W-1:0]          id;
        logic [owl_pkg::TIME_W-1:0]        arrival;
        logic signed [owl_pkg::WAIT_W-1:0] ticks;
        logic [owl_pkg::OCC_W-1:0]         occupancy;
    } wl_result_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    // list model, advanced once per accepted item
    logic [owl_pkg::ID_W-1:0]          wl_id    [LIST_DEPTH];
    logic [owl_pkg::TIME_W-1:0]        wl_arr   [LIST_DEPTH];
    logic signed [owl_pkg::WAIT_W-1:0] wl_ticks [LIST_DEPTH];
    int                                wl_count = 0;

    wl_op_t     op_queue[$];      // items waiting to be offered
    wl_result_t exp_results[$];   // results owed by the block, oldest first
    wl_op_t     cur_op;           // item currently on the s_* bus

    int items_accepted = 0;
    int results_seen   = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    int mismatch_cnt   = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ordered_wait_list_keyed_removal #(
        .DEPTH (LIST_DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Apply one operation to the list model and return the result the block owes.
    // Pop and both keyed removals share the take-and-compact path below.
    function automatic wl_result_t wait_list_apply(input wl_op_t op);
        wl_result_t r;
        int         hit;
        int         k;
        int         v;
        int         i;
        r.status  = owl_pkg::STAT_DONE;
        r.id      = '0;
        r.arrival = '0;
        r.ticks   = '0;
        hit       = -1;
        k         = int'(op.key);   // sign-extended 17-bit key
        case (op.mode)
            owl_pkg::MODE_PUSH:
            begin
                if (wl_count >= LIST_DEPTH)
                    r.status = owl_pkg::STAT_FULL;
                else
                begin
                    wl_id[wl_count]    = op.id;
                    wl_arr[wl_count]   = op.arrival;
                    wl_ticks[wl_count] = op.ticks;
                    wl_count++;
                end
            end
            owl_pkg::MODE_POP:
            begin
                if (wl_count == 0)
                    r.status = owl_pkg::STAT_NOMATCH;
                else
                    hit = 0;
            end
            owl_pkg::MODE_RM_ARR, owl_pkg::MODE_RM_WAIT:
            begin
                r.status = owl_pkg::STAT_NOMATCH;
                // first match from the head wins; arrival is unsigned, wait is signed
                for (i = 0; i < wl_count && hit < 0; i++)
                begin
                    if (op.mode == owl_pkg::MODE_RM_ARR)
                        v = int'(wl_arr[i]);
                    else
                        v = int'(wl_ticks[i]);
                    if (v == k)
                        hit = i;
                end
            end
            owl_pkg::MODE_TICK:
            begin
                // saturates at the most negative wait count
                for (i = 0; i < wl_count; i++)
                    if (wl_ticks[i] != TICKS_FLOOR)
                        wl_ticks[i] = owl_pkg::WAIT_W'(wl_ticks[i] - 1);
            end
            default: ;
        endcase
        if (hit >= 0)
        begin
            r.status  = owl_pkg::STAT_DONE;
            r.id      = wl_id[hit];
            r.arrival = wl_arr[hit];
            r.ticks   = wl_ticks[hit];
            for (i = hit; i + 1 < wl_count; i++)
            begin
                wl_id[i]    = wl_id[i + 1];
                wl_arr[i]   = wl_arr[i + 1];
                wl_ticks[i] = wl_ticks[i + 1];
            end
            wl_count--;
        end
        r.occupancy = owl_pkg::OCC_W'(wl_count);
        return r;
    endfunction

    function automatic wl_op_t op_make(input logic [owl_pkg::MODE_W-1:0] mode, input int id,
                                       input int arrival, input int ticks, input int key);
        wl_op_t op;
        op.mode    = mode;
        op.id      = owl_pkg::ID_W'(id);
        op.arrival = owl_pkg::TIME_W'(arrival);
        op.ticks   = owl_pkg::WAIT_W'(ticks);
        op.key     = owl_pkg::KEY_W'(key);
        return op;
    endfunction

    // Random operation. push_pct steers the fill level so that full and empty
    // lists both come up; removal keys mostly hit live entries.
    function automatic wl_op_t op_random(input int push_pct);
        wl_op_t op;
        int     pick;
        int     sel;
        op = op_make(owl_pkg::MODE_PUSH, $urandom, $urandom, $urandom, $urandom);
        pick = $urandom_range(0, 99);
        if (pick < push_pct)
        begin
            op.mode = owl_pkg::MODE_PUSH;
            // small arrival pool so duplicate keys exist and first-match matters
            if ($urandom_range(0, 99) < 40)
                op.arrival = owl_pkg::TIME_W'($urandom_range(0, 7));
            sel = $urandom_range(0, 99);
            if (sel < 25)
                op.ticks = owl_pkg::WAIT_W'($urandom_range(0, 6) - 3);
            else if (sel < 35)
                op.ticks = owl_pkg::WAIT_W'(int'($urandom_range(0, 1)) - 32768);
            else if (sel < 40)
                op.ticks = owl_pkg::WAIT_W'(32767);
        end
        else
        begin
            sel = $urandom_range(0, 9);
            if (sel < 2)
                op.mode = owl_pkg::MODE_POP;
            else if (sel < 5)
                op.mode = owl_pkg::MODE_RM_ARR;
            else if (sel < 8)
                op.mode = owl_pkg::MODE_RM_WAIT;
            else
                op.mode = owl_pkg::MODE_TICK;
            if (wl_count > 0 && $urandom_range(0, 99) < 75)
            begin
                sel = $urandom_range(0, wl_count - 1);
                if (op.mode == owl_pkg::MODE_RM_ARR)
                    op.key = owl_pkg::KEY_W'({1'b0, wl_arr[sel]});
                else if (op.mode == owl_pkg::MODE_RM_WAIT)
                    op.key = owl_pkg::KEY_W'(wl_ticks[sel]);
            end
        end
        return op;
    endfunction

    // Sender: offers the next pending item once the bus is free; the model
    // advances at the edge that accepts the item.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                exp_results.push_back(wait_list_apply(cur_op));
                items_accepted <= items_accepted + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (op_queue.size() > 0 &&
                    ((items_accepted >= CALM_LO && items_accepted < CALM_HI) ||
                     $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    cur_op = op_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'b0, cur_op.key, cur_op.ticks, cur_op.arrival, cur_op.id};
                    s_tuser  <= cur_op.mode;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Long hold-off on the result side: the sender keeps offering, the block
    // fills its single slot and drops s_tready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && results_seen == HOLD_AT)
        begin
            hold_left <= HOLD_CYC;
            hold_done <= 1'b1;
        end
    end

    // Receiver: random stalls, then a field-by-field check of each result item.
    always @(posedge clk or negedge rst_n)
    begin
        wl_result_t got;
        wl_result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                got.status    = m_tuser;
                got.id        = m_tdata[7:0];
                got.arrival   = m_tdata[23:8];
                got.ticks     = m_tdata[39:24];
                got.occupancy = m_tdata[44:40];
                if (exp_results.size() == 0)
                begin
                    $error("result item with nothing outstanding: status %0d occupancy %0d",
                           got.status, got.occupancy);
                    mismatch_cnt++;
                end
                else
                begin
                    want = exp_results.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        mismatch_cnt++;
                    end
                    if (got.id !== want.id)
                    begin
                        $error("out_thread_id: expected %0d, got %0d", want.id, got.id);
                        mismatch_cnt++;
                    end
                    if (got.arrival !== want.arrival)
                    begin
                        $error("out_arrival: expected %0d, got %0d", want.arrival, got.arrival);
                        mismatch_cnt++;
                    end
                    if (got.ticks !== want.ticks)
                    begin
                        $error("out_wait: expected %0d, got %0d", want.ticks, got.ticks);
                        mismatch_cnt++;
                    end
                    if (got.occupancy !== want.occupancy)
                    begin
                        $error("occupancy: expected %0d, got %0d",
                               want.occupancy, got.occupancy);
                        mismatch_cnt++;
                    end
                end
            end
            m_tready <= (hold_left == 0) &&
                        ((results_seen >= CALM_LO && results_seen < CALM_HI) ||
                         $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int m;
        int done_ops;
        int push_pct;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty list: pop and both removals find nothing, tick still reports done
        op_queue.push_back(op_make(owl_pkg::MODE_POP, 255, 65535, -1, -1));
        op_queue.push_back(op_make(owl_pkg::MODE_RM_ARR, 0, 0, 0, 0));
        op_queue.push_back(op_make(owl_pkg::MODE_RM_WAIT, 0, 0, 0, 0));
        op_queue.push_back(op_make(owl_pkg::MODE_TICK, 255, 65535, -1, 65535));
        // unused modes do nothing
        for (m = owl_pkg::MODE_TICK + 1; m <= MODE_LAST; m++)
            op_queue.push_back(op_make(owl_pkg::MODE_W'(m),
                                       $urandom, $urandom, $urandom, $urandom));
        // field extremes, a wait one above the floor and a duplicate arrival
        op_queue.push_back(op_make(owl_pkg::MODE_PUSH, 255, 65535, 32767, 0));
        op_queue.push_back(op_make(owl_pkg::MODE_PUSH, 0, 0, -32768, 0));
        op_queue.push_back(op_make(owl_pkg::MODE_PUSH, 8'hA5, 16'h5A5A, -32767, 0));
        op_queue.push_back(op_make(owl_pkg::MODE_PUSH, 7, 65535, 1, 0));
        // tick: floor holds, -32767 reaches the floor, 1 reaches 0
        op_queue.push_back(op_make(owl_pkg::MODE_TICK, 0, 0, 0, 0));
        // wait key above 32767 and arrival key -1 (low bits all ones) never match
        op_queue.push_back(op_make(owl_pkg::MODE_RM_WAIT, 0, 0, 0, 65535));
        op_queue.push_back(op_make(owl_pkg::MODE_RM_ARR, 0, 0, 0, -1));
        // key below -32768 whose low 16 bits are zero
        op_queue.push_back(op_make(owl_pkg::MODE_RM_ARR, 0, 0, 0, -65536));
        op_queue.push_back(op_make(owl_pkg::MODE_RM_WAIT, 0, 0, 0, -65536));
        // first match from the head, then compaction keeps order
        op_queue.push_back(op_make(owl_pkg::MODE_RM_ARR, 0, 0, 0, 65535));
        op_queue.push_back(op_make(owl_pkg::MODE_RM_WAIT, 0, 0, 0, -32768));
        op_queue.push_back(op_make(owl_pkg::MODE_RM_WAIT, 0, 0, 0, 0));
        op_queue.push_back(op_make(owl_pkg::MODE_POP, 0, 0, 0, 0));
        op_queue.push_back(op_make(owl_pkg::MODE_POP, 0, 0, 0, 0));

        // random part in phases of filling, mixing and draining; keys are
        // picked from the model, which may trail the queue by an item or two
        done_ops = 0;
        while (done_ops < RAND_OPS)
        begin
            while (op_queue.size() >= 2)
                @(negedge clk);
            case ((done_ops / 40) % 3)
                0:       push_pct = 80;
                1:       push_pct = 40;
                default: push_pct = 15;
            endcase
            if ($urandom_range(0, 99) < 4)
                op_queue.push_back(op_make(
                    owl_pkg::MODE_W'($urandom_range(owl_pkg::MODE_TICK + 1, MODE_LAST)),
                    $urandom, $urandom, $urandom, $urandom));
            else
            begin
                op_queue.push_back(op_random(push_pct));
                done_ops++;
            end
        end

        while (op_queue.size() != 0 || s_tvalid || exp_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);
        if (mismatch_cnt == 0)
            $display("ordered_wait_list_keyed_removal regression: pass");
        else
            $display("ordered_wait_list_keyed_removal regression: fail");
        $finish;
    end

    // Hang guard, several times the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("ordered_wait_list_keyed_removal regression: fail");
        $finish;
    end

endmodule
